### rtl/core/esm_pkg.sv
// Shared types, constants and pool arithmetic for the effect slot manager.
// No dependencies; esm_ctrl and the top level refer to it by scoped name.
package esm_pkg;

  localparam int SLOT_COUNT  = 32;
  localparam int SLOT_DEPTH  = SLOT_COUNT + 1;
  localparam int SLOT_AW     = $clog2(SLOT_DEPTH);

  localparam logic [7:0]  SLOT_MAX    = 8'(SLOT_COUNT);
  localparam logic [7:0]  SLOT_SWEEP  = 8'(SLOT_COUNT + 1);
  localparam logic [7:0]  FREE_ALL    = 8'hFF;
  localparam logic [15:0] POOL_SIZE   = 16'(4096);
  localparam logic [15:0] EFFECT_SIZE = 16'(64);

  // Device control codes
  localparam logic [7:0] CTL_ENABLE   = 8'h01;
  localparam logic [7:0] CTL_DISABLE  = 8'h02;
  localparam logic [7:0] CTL_STOP_ALL = 8'h03;
  localparam logic [7:0] CTL_RESET    = 8'h04;
  localparam logic [7:0] CTL_PAUSE    = 8'h05;
  localparam logic [7:0] CTL_CONTINUE = 8'h06;

  // Slot entry: bit0 allocated, bit1 playing
  localparam logic [1:0] ENTRY_EMPTY     = 2'b00;
  localparam logic [1:0] ENTRY_ALLOCATED = 2'b01;
  localparam logic [1:0] KEEP_NONE       = 2'b00;
  localparam logic [1:0] KEEP_ALLOCATED  = 2'b01;

  typedef enum logic [2:0] {
    OP_CREATE     = 3'd0,
    OP_START      = 3'd1,
    OP_START_SOLO = 3'd2,
    OP_STOP       = 3'd3,
    OP_FREE       = 3'd4,
    OP_DEVCTL     = 3'd5,
    OP_POOL_RESET = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] slot;
    logic [7:0] control;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  new_slot;
    logic        load_status;
    logic [15:0] pool_available;
    logic        actuators_enabled;
    logic        paused;
    logic [1:0]  slot_state;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] waddr;
    logic [1:0]         wdata;
    logic [SLOT_AW-1:0] raddr;
  } ram_req_t;

  function automatic logic [15:0] pool_take(input logic [15:0] pool);
    return (pool > EFFECT_SIZE) ? (pool - EFFECT_SIZE) : 16'd0;
  endfunction

  function automatic logic [15:0] pool_give(input logic [15:0] pool);
    logic [16:0] sum;
    sum = {1'b0, pool} + {1'b0, EFFECT_SIZE};
    return (sum > {1'b0, POOL_SIZE}) ? POOL_SIZE : sum[15:0];
  endfunction

endpackage

### rtl/core/esm_cmd_if.sv
// Command channel: valid/ready handshake carrying one host PID command.
// Depends on nothing.
interface esm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] slot;
  logic [7:0] control;

  modport source (output valid, output op, output slot, output control, input ready);
  modport sink   (input valid, input op, input slot, input control, output ready);
endinterface

### rtl/core/esm_rsp_if.sv
// Response channel: valid/ready handshake carrying one command result.
// Depends on nothing.
interface esm_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  new_slot;
  logic        load_status;
  logic [15:0] pool_available;
  logic        actuators_enabled;
  logic        paused;
  logic [1:0]  slot_state;

  modport source (output valid, output new_slot, output load_status, output pool_available,
                  output actuators_enabled, output paused, output slot_state, input ready);
  modport sink   (input valid, input new_slot, input load_status, input pool_available,
                  input actuators_enabled, input paused, input slot_state, output ready);
endinterface

### rtl/core/esm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module esm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/esm_ctrl.sv
// Command sequencer: dispatch, slot table sweeps, pointer scan, pool and flags.
// Uses esm_pkg; drives the slot table RAM through an esm_pkg::ram_req_t.
module esm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  esm_pkg::cmd_t     cmd,
  output logic              res_valid,
  input  logic              res_take,
  output esm_pkg::res_t     res,
  output esm_pkg::ram_req_t ram_req,
  input  logic [1:0]        ram_rdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_RD,
    S_WR,
    S_CREATE,
    S_SCAN,
    S_SHOW,
    S_SHOW_WAIT,
    S_DONE
  } state_t;

  state_t      state;
  logic [2:0]  op_r;
  logic [7:0]  slot_r;
  logic [7:0]  idx;
  logic [1:0]  keep_r;
  logic        init_r;
  logic [7:0]  next_free;
  logic [15:0] pool;
  logic        act_flag;
  logic        pause_flag;
  logic [7:0]  given_r;
  logic        full_r;
  logic        show_ok_r;
  logic [7:0]  show_addr_r;
  logic [1:0]  slot_state_r;

  logic        slot_ok;
  logic        cmd_ok;
  logic [8:0]  idx_inc;
  logic [7:0]  idx_dec;
  logic [8:0]  nf_inc;
  logic [1:0]  wr_entry;

  assign slot_ok = slot_r <= esm_pkg::SLOT_MAX;
  assign cmd_ok  = cmd.slot <= esm_pkg::SLOT_MAX;
  assign idx_inc = {1'b0, idx} + 9'd1;
  assign idx_dec = 8'(idx - 8'd1);
  assign nf_inc  = {1'b0, next_free} + 9'd1;

  assign cmd_ready = state == S_IDLE;
  assign res_valid = state == S_DONE;

  assign res.new_slot          = given_r;
  assign res.load_status       = full_r;
  assign res.pool_available    = pool;
  assign res.actuators_enabled = act_flag;
  assign res.paused            = pause_flag;
  assign res.slot_state        = slot_state_r;

  // New entry for a single-slot read-modify-write
  always_comb begin
    case (esm_pkg::op_t'(op_r))
      esm_pkg::OP_START, esm_pkg::OP_START_SOLO: wr_entry = {1'b1, ram_rdata[0]};
      esm_pkg::OP_STOP:                          wr_entry = {1'b0, ram_rdata[0]};
      default:                                   wr_entry = esm_pkg::ENTRY_EMPTY;
    endcase
  end

  // Table port decode
  always_comb begin
    ram_req = '0;
    case (state)
      S_SWEEP: begin
        // read idx, write back idx-1 with the kept bits
        if (idx <= esm_pkg::SLOT_MAX) begin
          ram_req.raddr = idx[esm_pkg::SLOT_AW-1:0];
        end
        ram_req.we    = idx != 8'd0;
        ram_req.waddr = idx_dec[esm_pkg::SLOT_AW-1:0];
        ram_req.wdata = ram_rdata & keep_r;
      end
      S_RD: begin
        ram_req.raddr = slot_r[esm_pkg::SLOT_AW-1:0];
      end
      S_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = slot_r[esm_pkg::SLOT_AW-1:0];
        ram_req.wdata = wr_entry;
      end
      S_CREATE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = next_free[esm_pkg::SLOT_AW-1:0];
        ram_req.wdata = esm_pkg::ENTRY_ALLOCATED;
        ram_req.raddr = nf_inc[esm_pkg::SLOT_AW-1:0];
      end
      S_SCAN: begin
        ram_req.raddr = idx_inc[esm_pkg::SLOT_AW-1:0];
      end
      S_SHOW: begin
        ram_req.raddr = show_addr_r[esm_pkg::SLOT_AW-1:0];
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      idx        <= 8'd0;
      keep_r     <= esm_pkg::KEEP_NONE;
      init_r     <= 1'b1;
      next_free  <= 8'd1;
      pool       <= esm_pkg::POOL_SIZE;
      act_flag   <= 1'b1;
      pause_flag <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op_r        <= cmd.op;
            slot_r      <= cmd.slot;
            given_r     <= 8'd0;
            full_r      <= 1'b0;
            show_ok_r   <= cmd_ok;
            show_addr_r <= cmd.slot;
            idx         <= 8'd0;
            state       <= S_SHOW;
            case (esm_pkg::op_t'(cmd.op))
              esm_pkg::OP_CREATE: begin
                if (next_free >= esm_pkg::SLOT_MAX) begin
                  full_r    <= 1'b1;
                  show_ok_r <= 1'b0;
                end else begin
                  state <= S_CREATE;
                end
              end
              esm_pkg::OP_START, esm_pkg::OP_STOP: begin
                if (cmd_ok) begin
                  state <= S_RD;
                end
              end
              esm_pkg::OP_START_SOLO: begin
                keep_r <= esm_pkg::KEEP_ALLOCATED;
                state  <= S_SWEEP;
              end
              esm_pkg::OP_FREE: begin
                if (cmd.slot == esm_pkg::FREE_ALL) begin
                  keep_r    <= esm_pkg::KEEP_NONE;
                  next_free <= 8'd1;
                  pool      <= esm_pkg::POOL_SIZE;
                  state     <= S_SWEEP;
                end else if (cmd_ok) begin
                  state <= S_RD;
                end
              end
              esm_pkg::OP_DEVCTL: begin
                case (cmd.control)
                  esm_pkg::CTL_ENABLE:   act_flag   <= 1'b1;
                  esm_pkg::CTL_DISABLE:  act_flag   <= 1'b0;
                  esm_pkg::CTL_PAUSE:    pause_flag <= 1'b1;
                  esm_pkg::CTL_CONTINUE: pause_flag <= 1'b0;
                  esm_pkg::CTL_STOP_ALL: begin
                    keep_r <= esm_pkg::KEEP_ALLOCATED;
                    state  <= S_SWEEP;
                  end
                  esm_pkg::CTL_RESET: begin
                    keep_r    <= esm_pkg::KEEP_NONE;
                    next_free <= 8'd1;
                    pool      <= esm_pkg::POOL_SIZE;
                    state     <= S_SWEEP;
                  end
                  default: begin
                    state <= S_SHOW;
                  end
                endcase
              end
              esm_pkg::OP_POOL_RESET: begin
                keep_r    <= esm_pkg::KEEP_NONE;
                next_free <= 8'd1;
                pool      <= esm_pkg::POOL_SIZE;
                state     <= S_SWEEP;
              end
              default: begin
                state <= S_SHOW;
              end
            endcase
          end
        end

        S_SWEEP: begin
          if (idx == esm_pkg::SLOT_SWEEP) begin
            if (init_r) begin
              init_r <= 1'b0;
              state  <= S_IDLE;
            end else if (esm_pkg::op_t'(op_r) == esm_pkg::OP_START_SOLO && slot_ok) begin
              state <= S_RD;
            end else begin
              state <= S_SHOW;
            end
          end else begin
            idx <= 8'(idx + 8'd1);
          end
        end

        S_RD: begin
          state <= S_WR;
        end

        S_WR: begin
          if (esm_pkg::op_t'(op_r) == esm_pkg::OP_FREE) begin
            if (ram_rdata[0]) begin
              pool <= esm_pkg::pool_give(pool);
            end
            if (slot_r != 8'd0 && slot_r < next_free) begin
              next_free <= slot_r;
            end
          end
          state <= S_SHOW;
        end

        S_CREATE: begin
          given_r     <= next_free;
          show_ok_r   <= 1'b1;
          show_addr_r <= next_free;
          pool        <= esm_pkg::pool_take(pool);
          if (nf_inc >= {1'b0, esm_pkg::SLOT_MAX}) begin
            next_free <= esm_pkg::SLOT_MAX;
            state     <= S_SHOW;
          end else begin
            idx   <= nf_inc[7:0];
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          // ram_rdata holds the entry of candidate idx
          if (ram_rdata == esm_pkg::ENTRY_EMPTY) begin
            next_free <= idx;
            state     <= S_SHOW;
          end else if (idx_inc >= {1'b0, esm_pkg::SLOT_MAX}) begin
            next_free <= esm_pkg::SLOT_MAX;
            state     <= S_SHOW;
          end else begin
            idx <= idx_inc[7:0];
          end
        end

        S_SHOW: begin
          if (show_ok_r) begin
            state <= S_SHOW_WAIT;
          end else begin
            slot_state_r <= esm_pkg::ENTRY_EMPTY;
            state        <= S_DONE;
          end
        end

        S_SHOW_WAIT: begin
          slot_state_r <= ram_rdata;
          state        <= S_DONE;
        end

        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/ffb_effect_slot_manager_unit.sv
// Top level of the force-feedback effect slot manager.
// Uses esm_pkg, esm_cmd_if, esm_rsp_if, esm_ram and esm_ctrl.
//
// Usage:
//   cmd  - one host PID command per transaction: op, slot, control.
//   rsp  - one result per command: new_slot, load_status, pool_available,
//          actuators_enabled, paused, slot_state (addressed or new slot).
// The slot table (allocated/playing per slot) lives in a small RAM, one
// entry per slot 0..SLOT_COUNT; the sequencer reads, writes or sweeps it.
// Steps from the accepted command to rsp.valid (a slot out of range or
// a full table skips to show, which reads the slot only when in range):
//   flag/device control and unknown ops      show
//   start, stop, free of one slot            read, write, show
//   create                                   write, pointer scan, show
//   start solo, stop all, free all, resets   sweep; start solo then as start
// The table port (one read, one write per cycle) paces these steps.
// cmd.ready is high only while the sequencer is idle: one command at a time.
// Reset: synchronous; afterwards a clearing pass zeroes the table with
// cmd.ready low. Flags come up enabled, not paused, pool at POOL_SIZE,
// next free slot 1.
// A stalled receiver: the result sits in the output register; the next
// command is still taken and runs, and waits in the sequencer until the
// register frees.
module ffb_effect_slot_manager_unit (
  input logic     clk,
  input logic     rst,
  esm_cmd_if.sink cmd,
  esm_rsp_if.source rsp
);

  esm_pkg::cmd_t     cmd_data;
  esm_pkg::res_t     res;
  esm_pkg::res_t     out_r;
  esm_pkg::ram_req_t ram_req;
  logic [1:0]        ram_rdata;
  logic              res_valid;
  logic              res_take;
  logic              out_valid;

  assign cmd_data.op      = cmd.op;
  assign cmd_data.slot    = cmd.slot;
  assign cmd_data.control = cmd.control;

  esm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd       (cmd_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // Slot table: {playing, allocated} per slot
  esm_ram #(
    .WIDTH (2),
    .DEPTH (esm_pkg::SLOT_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Output register: loads when empty or draining this cycle
  assign res_take = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.new_slot          = out_r.new_slot;
  assign rsp.load_status       = out_r.load_status;
  assign rsp.pool_available    = out_r.pool_available;
  assign rsp.actuators_enabled = out_r.actuators_enabled;
  assign rsp.paused            = out_r.paused;
  assign rsp.slot_state        = out_r.slot_state;

endmodule
